FILE: rtl/resp_request_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the request parser
// Shorthand for concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_PARSER_MACROS_SVH
`define RESP_REQUEST_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RRP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rrp_pkg.sv
// ----------------------------------------------------------------------------
// Request parser package
// Shared types, register indexes, result codes and default widths.
// ----------------------------------------------------------------------------
package rrp_pkg;

	// default counter widths
	localparam int RRP_COUNT_WIDTH  = 32;
	localparam int RRP_LENGTH_WIDTH = 32;

	// configuration port
	localparam int CFG_DATA_W = 32;
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t CFG_MAX_ARRAY_COUNT = 1'd0;
	localparam cfg_index_t CFG_MAX_BULK_LENGTH = 1'd1;

	localparam logic [31:0] MAX_ARRAY_COUNT_RST = 32'd1048576;
	localparam logic [30:0] MAX_BULK_LENGTH_RST = 31'd536870912;

	// byte kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_ARG  = 2'd2;

	// status codes
	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_BAD_FIRST = 3'd1;
	localparam logic [2:0] STATUS_BAD_LINE  = 3'd2;
	localparam logic [2:0] STATUS_BAD_NUM   = 3'd3;
	localparam logic [2:0] STATUS_NO_DOLLAR = 3'd4;
	localparam logic [2:0] STATUS_TRUNC     = 3'd5;
	localparam logic [2:0] STATUS_TRAILING  = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_message;
	} rrp_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  byte_kind;
		logic [31:0] arg_index;
		logic        field_end;
		logic        message_done;
		logic [2:0]  status;
	} rrp_out_t;

	typedef struct packed {
		logic [31:0] max_array_count;
		logic [30:0] max_bulk_length;
	} rrp_cfg_t;

endpackage

FILE: rtl/rrp_in_stage.sv
// ----------------------------------------------------------------------------
// Request parser input stage
// Registers one incoming byte and stalls the sender while it cannot move on.
// ----------------------------------------------------------------------------
module rrp_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  rrp_pkg::rrp_in_t in_data,
	input  logic             advance,
	output logic             valid_s1,
	output rrp_pkg::rrp_in_t item_s1
);
	import rrp_pkg::*;

	logic accept;

	// stall only while the held item cannot advance
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// hold or refill the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	// capture the payload on a transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

endmodule

FILE: rtl/rrp_core.sv
// ----------------------------------------------------------------------------
// Request parser core
// Phase register, line and number tracking, and per-byte result logic.
// ----------------------------------------------------------------------------
module rrp_core #(
	parameter int COUNT_WIDTH  = rrp_pkg::RRP_COUNT_WIDTH,
	parameter int LENGTH_WIDTH = rrp_pkg::RRP_LENGTH_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rrp_pkg::rrp_in_t  item,
	input  rrp_pkg::rrp_cfg_t cfg,
	output rrp_pkg::rrp_out_t result
);
	import rrp_pkg::*;

	typedef enum logic [3:0] {
		PH_HEAD, PH_INLINE, PH_COUNT, PH_LENHDR, PH_LEN,
		PH_DATA, PH_SKIP, PH_DONE, PH_ERR
	} phase_t;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [32:0] NUM_SAT  = 33'h1_0000_0000;

	function automatic logic is_lower(input logic [7:0] ch);
		is_lower = (ch >= 8'h61) && (ch <= 8'h7A);
	endfunction

	function automatic logic is_upper(input logic [7:0] ch);
		is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
	endfunction

	function automatic logic [7:0] upcase(input logic [7:0] ch);
		upcase = is_lower(ch) ? ch - 8'd32 : ch;
	endfunction

	// state
	phase_t                  phase_q, n_phase;
	logic [COUNT_WIDTH-1:0]  elem_left_q, n_elem_left;
	logic [COUNT_WIDTH-1:0]  elem_idx_q, n_elem_idx;
	logic [LENGTH_WIDTH-1:0] data_left_q, n_data_left;
	logic [32:0]             acc_q, n_acc;
	logic                    have_digit_q, n_have_digit;
	logic [1:0]              line_cnt_q, n_line_cnt;
	logic [7:0]              held_q, n_held;
	logic [2:0]              pend_q, n_pend;
	logic [1:0]              skip_q, n_skip;
	logic [2:0]              err_q, n_err;

	// per-byte helpers
	logic [7:0]  c;
	logic        eom;
	logic        held_first;
	logic        held_digit;
	logic [36:0] acc_sum;
	logic [32:0] acc_next;
	logic        count_bad;
	logic        len_bad;
	logic [31:0] cur_arg;
	logic        clear_line;
	logic [7:0]  r_byte;
	logic [1:0]  r_kind;
	logic [31:0] r_idx;
	logic        r_fe;

	assign c          = item.in_byte;
	assign eom        = item.end_of_message;
	assign held_first = (line_cnt_q == 2'd1);
	assign held_digit = (held_q >= CH_0) && (held_q <= CH_9);
	assign cur_arg    = 32'(elem_idx_q - COUNT_WIDTH'(1));

	// decimal accumulate with saturation above 32 bits
	assign acc_sum  = 37'(acc_q) * 37'd10 + 37'(held_q - CH_0);
	assign acc_next = (|acc_sum[36:32]) ? NUM_SAT : acc_sum[32:0];

	// number limit checks
	assign count_bad = !have_digit_q || (acc_q > {1'b0, cfg.max_array_count})
		|| (|(acc_q >> COUNT_WIDTH));
	assign len_bad   = !have_digit_q || (acc_q > {2'b0, cfg.max_bulk_length})
		|| (|(acc_q >> LENGTH_WIDTH));

	// next state and result for the byte in the stage
	always_comb begin
		n_phase      = phase_q;
		n_elem_left  = elem_left_q;
		n_elem_idx   = elem_idx_q;
		n_data_left  = data_left_q;
		n_acc        = acc_q;
		n_have_digit = have_digit_q;
		n_line_cnt   = line_cnt_q;
		n_held       = held_q;
		n_pend       = pend_q;
		n_skip       = skip_q;
		n_err        = err_q;
		clear_line   = 1'b0;
		r_byte       = 8'd0;
		r_kind       = KIND_NONE;
		r_idx        = 32'd0;
		r_fe         = 1'b0;

		unique case (phase_q) inside
			PH_HEAD, PH_INLINE, PH_COUNT, PH_LENHDR, PH_LEN: begin
				if (c == CH_LF) begin
					// close the header line
					if (line_cnt_q < 2'd2 || held_q != CH_CR) begin
						n_err   = STATUS_BAD_LINE;
						n_phase = PH_ERR;
					end else if (pend_q != STATUS_OK) begin
						n_err   = pend_q;
						n_phase = PH_ERR;
					end else if (phase_q == PH_INLINE) begin
						r_fe    = 1'b1;
						n_phase = PH_DONE;
					end else if (phase_q == PH_COUNT) begin
						if (count_bad) begin
							n_err   = STATUS_BAD_NUM;
							n_phase = PH_ERR;
						end else begin
							n_elem_left = COUNT_WIDTH'(acc_q);
							n_elem_idx  = '0;
							n_phase     = (acc_q != 33'd0) ? PH_LENHDR : PH_DONE;
							clear_line  = 1'b1;
						end
					end else if (phase_q == PH_LEN) begin
						if (len_bad) begin
							n_err   = STATUS_BAD_NUM;
							n_phase = PH_ERR;
						end else begin
							n_data_left = LENGTH_WIDTH'(acc_q);
							clear_line  = 1'b1;
							if (acc_q == 33'd0) begin
								// empty bulk string closes its field at once
								r_fe    = 1'b1;
								r_idx   = (elem_idx_q != '0) ? cur_arg : 32'd0;
								n_phase = PH_SKIP;
								n_skip  = 2'd2;
							end else begin
								n_phase = PH_DATA;
							end
						end
					end else begin
						n_err   = STATUS_BAD_LINE;
						n_phase = PH_ERR;
					end
				end else begin
					// use the held byte now that it is not the CR before LF
					if (line_cnt_q != 2'd0) begin
						case (phase_q)
							PH_HEAD: begin
								if (held_first) begin
									if (is_upper(held_q) || is_lower(held_q)) begin
										r_byte  = upcase(held_q);
										r_kind  = KIND_CMD;
										n_phase = PH_INLINE;
									end else if (held_q == CH_STAR) begin
										n_phase = PH_COUNT;
									end else begin
										n_pend = STATUS_BAD_FIRST;
									end
								end
							end
							PH_INLINE: begin
								r_byte = upcase(held_q);
								r_kind = KIND_CMD;
							end
							PH_LENHDR: begin
								if (held_first) begin
									if (held_q == CH_DOLLAR) begin
										n_phase = PH_LEN;
									end else begin
										n_pend = STATUS_NO_DOLLAR;
									end
								end
							end
							default: begin
								if (held_digit) begin
									n_have_digit = 1'b1;
									n_acc        = acc_next;
								end else if (pend_q == STATUS_OK) begin
									n_pend = STATUS_BAD_NUM;
								end
							end
						endcase
					end
					n_held = c;
					if (line_cnt_q != 2'd3) begin
						n_line_cnt = line_cnt_q + 2'd1;
					end
				end
			end
			PH_DATA: begin
				// pass a data byte through
				if (elem_idx_q == '0) begin
					r_byte = upcase(c);
					r_kind = KIND_CMD;
				end else begin
					r_byte = c;
					r_kind = KIND_ARG;
					r_idx  = cur_arg;
				end
				n_data_left = data_left_q - LENGTH_WIDTH'(1);
				if (data_left_q == LENGTH_WIDTH'(1)) begin
					r_fe    = 1'b1;
					n_phase = PH_SKIP;
					n_skip  = 2'd2;
				end
			end
			PH_SKIP: begin
				// drop the two bytes after the data
				if (skip_q != 2'd0) begin
					n_skip = skip_q - 2'd1;
				end
				if (n_skip == 2'd0) begin
					n_elem_idx  = elem_idx_q + COUNT_WIDTH'(1);
					n_elem_left = elem_left_q - COUNT_WIDTH'(1);
					n_phase     = (elem_left_q == COUNT_WIDTH'(1)) ? PH_DONE : PH_LENHDR;
					clear_line  = 1'b1;
				end
			end
			PH_DONE: begin
				n_err   = STATUS_TRAILING;
				n_phase = PH_ERR;
			end
			default: begin
			end
		endcase

		// message ended before the request was complete
		if (eom && n_err == STATUS_OK && n_phase != PH_DONE) begin
			n_err   = STATUS_TRUNC;
			n_phase = PH_ERR;
		end

		if (clear_line) begin
			n_line_cnt   = 2'd0;
			n_held       = 8'd0;
			n_pend       = STATUS_OK;
			n_acc        = 33'd0;
			n_have_digit = 1'b0;
		end
	end

	// result of this byte
	always_comb begin
		result.out_byte     = r_byte;
		result.byte_kind    = r_kind;
		result.arg_index    = r_idx;
		result.field_end    = r_fe;
		result.message_done = eom;
		result.status       = n_err;
	end

	// advance state; restart on end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEAD;
			elem_left_q  <= '0;
			elem_idx_q   <= '0;
			data_left_q  <= '0;
			acc_q        <= 33'd0;
			have_digit_q <= 1'b0;
			line_cnt_q   <= 2'd0;
			held_q       <= 8'd0;
			pend_q       <= STATUS_OK;
			skip_q       <= 2'd0;
			err_q        <= STATUS_OK;
		end else if (advance) begin
			if (eom) begin
				phase_q      <= PH_HEAD;
				elem_left_q  <= '0;
				elem_idx_q   <= '0;
				data_left_q  <= '0;
				acc_q        <= 33'd0;
				have_digit_q <= 1'b0;
				line_cnt_q   <= 2'd0;
				held_q       <= 8'd0;
				pend_q       <= STATUS_OK;
				skip_q       <= 2'd0;
				err_q        <= STATUS_OK;
			end else begin
				phase_q      <= n_phase;
				elem_left_q  <= n_elem_left;
				elem_idx_q   <= n_elem_idx;
				data_left_q  <= n_data_left;
				acc_q        <= n_acc;
				have_digit_q <= n_have_digit;
				line_cnt_q   <= n_line_cnt;
				held_q       <= n_held;
				pend_q       <= n_pend;
				skip_q       <= n_skip;
				err_q        <= n_err;
			end
		end
	end

endmodule

FILE: rtl/resp_request_parser.sv
// ----------------------------------------------------------------------------
// Request message parser
// Byte-stream parser for inline and array requests with a sticky status.
// ----------------------------------------------------------------------------
// One byte enters per cycle while out_stall is low and gives exactly one
// result: the byte is registered, the phase and counter logic works on it in
// the next cycle, and the result lands in the output register. Sustained rate
// is one byte per clock while out_stall is low, set by the update of the phase
// register, the length and element counters and the decimal accumulator. A
// result may wait in the output register while the next byte is taken. Command
// bytes come out upper-cased with byte_kind 1, argument bytes with byte_kind 2
// and their index; field_end marks the last result of a field and message_done
// echoes end_of_message, at which point status is final and the parser restarts.
// Write the limit registers only while no message is in flight.
`include "resp_request_parser_macros.svh"

module resp_request_parser #(
	parameter int COUNT_WIDTH  = rrp_pkg::RRP_COUNT_WIDTH,
	parameter int LENGTH_WIDTH = rrp_pkg::RRP_LENGTH_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rrp_pkg::rrp_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rrp_pkg::rrp_out_t                 out_data,
	input  logic                              cfg_we,
	input  rrp_pkg::cfg_index_t               cfg_index,
	input  logic [rrp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import rrp_pkg::*;

	logic     valid_s1;
	rrp_in_t  item_s1;
	logic     advance;
	rrp_out_t result;
	rrp_cfg_t cfg_q;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_array_count <= MAX_ARRAY_COUNT_RST;
			cfg_q.max_bulk_length <= MAX_BULK_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_ARRAY_COUNT: cfg_q.max_array_count <= cfg_wdata[31:0];
				CFG_MAX_BULK_LENGTH: cfg_q.max_bulk_length <= cfg_wdata[30:0];
			endcase
		end
	end

	// move on when the output register is free or being emptied
	assign advance = valid_s1 && (!out_valid || !out_stall);

	rrp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rrp_core #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// output register: load on advance, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

	`RRP_ASSERT_SAME(a_stall_when_full, in_stall, valid_s1 && out_valid && out_stall, "input stalled while pipeline can move")
	`RRP_ASSERT_NEXT(a_result_follows, advance, out_valid, "advanced byte produced no result")
	`RRP_ASSERT_SAME(a_no_payload_zero, out_valid && out_data.byte_kind == KIND_NONE, out_data.out_byte == 8'd0, "payload byte set on a kind-0 result")

endmodule
